// ===== rtl/truss_element_stiffness_macros.svh =====
// assertion macros shared by the truss element stiffness rtl
`ifndef TRUSS_ELEMENT_STIFFNESS_MACROS_SVH
`define TRUSS_ELEMENT_STIFFNESS_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define TES_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("truss element stiffness assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define TES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("truss element stiffness assertion failed");

`endif

// ===== rtl/tes_pkg.sv =====
// types, constants and index helpers for the truss element stiffness block
package tes_pkg;

  localparam int unsigned Axes        = 3;
  localparam int unsigned Pairs       = 6;
  localparam int unsigned MagW        = 32;
  localparam int unsigned SumW        = 66;
  localparam int unsigned LenW        = 33;
  localparam int unsigned RemW        = 34;
  localparam int unsigned SqRemW      = 35;
  localparam int unsigned QW          = 31;
  localparam int unsigned EaW         = 64;
  localparam int unsigned QqW         = 61;
  localparam int unsigned ProdW       = 128;
  localparam int unsigned QuotW       = 47;
  localparam int unsigned EntryW      = 48;
  localparam int unsigned SquareSteps = 4;
  localparam int unsigned SqrtSteps   = 33;
  localparam int unsigned QSteps      = 31;
  localparam int unsigned MulSteps    = 6;
  localparam int unsigned DivSteps    = 47;

  localparam logic [EntryW-1:0] EntryPosMax = 48'h7FFF_FFFF_FFFF;
  localparam logic [EntryW-1:0] EntryNegMag = 48'h8000_0000_0000;
  localparam logic [QW-1:0]     QOne        = 31'h4000_0000;
  localparam logic [2:0]        LastIdx     = 3'd5;

  typedef struct packed {
    logic [Axes-1:0][MagW-1:0] mag;
    logic [Axes-1:0]           neg;
    logic                      zero;
    logic [31:0]               modulus;
    logic [31:0]               area;
  } tes_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StSquare,
    StSqrt,
    StQdiv,
    StMul,
    StDiv,
    StHand
  } tes_state_e;

  // axis of a dof index (0..5)
  function automatic logic [1:0] axis_of(input logic [2:0] idx);
    logic [2:0] t;
    t = (idx >= 3'd3) ? idx - 3'd3 : idx;
    return t[1:0];
  endfunction

  // second node block
  function automatic logic node_of(input logic [2:0] idx);
    return idx >= 3'd3;
  endfunction

  // symmetric axis pair to magnitude slot
  function automatic logic [2:0] pair_of(input logic [1:0] ar, input logic [1:0] ac);
    logic [1:0] lo;
    logic [1:0] hi;
    logic [2:0] p;
    lo = (ar < ac) ? ar : ac;
    hi = (ar < ac) ? ac : ar;
    unique case ({lo, hi})
      4'b0000: p = 3'd0;
      4'b0001: p = 3'd1;
      4'b0010: p = 3'd2;
      4'b0101: p = 3'd3;
      4'b0110: p = 3'd4;
      4'b1010: p = 3'd5;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

  function automatic logic [1:0] pair_row(input logic [2:0] p);
    logic [1:0] a;
    unique case (p)
      3'd0, 3'd1, 3'd2: a = 2'd0;
      3'd3, 3'd4:       a = 2'd1;
      3'd5:             a = 2'd2;
      default:          a = 2'd0;
    endcase
    return a;
  endfunction

  function automatic logic [1:0] pair_col(input logic [2:0] p);
    logic [1:0] a;
    unique case (p)
      3'd0:             a = 2'd0;
      3'd1, 3'd3:       a = 2'd1;
      3'd2, 3'd4, 3'd5: a = 2'd2;
      default:          a = 2'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/truss_element_stiffness.sv =====
// top level of the space truss element stiffness block
//
// input channel: one transfer carries a bar element, both end nodes in
// signed Q16.16, modulus E and area A (Q16.16). output channel: 36
// transfers per element, the 6x6 global stiffness entries row-major
// (signed Q15.32, saturated), with row, column, zero_length and last
// (set on row 5, column 5).
// path from input transfer to the first entry transfer: the input register
// and queue, the pop, the squares and E*A on one shared 32x32 multiplier,
// a bit-serial square root, the three cosines (parallel divider lanes),
// six EA*cos*cos products, six parallel divides by L, then the load of
// the output bank.
// the back takes one element at a time through that serial sequencer; the
// 36 entries of one element stream out of the output bank while the next
// element is being computed.
// a small queue sits between the front (input register and classify)
// and the back, so inputs keep being taken while the back is busy.
// reset clears all handshake state; no element is in flight afterward.
// a stalled receiver holds the bank; the back then waits with its
// finished element, and the queue and front fill before in_ready_o drops.
module truss_element_stiffness #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] first_x_i,
  input  logic signed [31:0] first_y_i,
  input  logic signed [31:0] first_z_i,
  input  logic signed [31:0] second_x_i,
  input  logic signed [31:0] second_y_i,
  input  logic signed [31:0] second_z_i,
  input  logic [31:0]        modulus_i,
  input  logic [31:0]        area_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         row_o,
  output logic [2:0]         column_o,
  output logic signed [47:0] entry_o,
  output logic               zero_length_o,
  output logic               last_o
);
  import tes_pkg::*;

  // front to queue
  logic      push, full;
  tes_item_t front_item;
  // queue to back
  logic      pop, empty;
  tes_item_t queue_item;

  tes_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .first_z_i  (first_z_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .second_z_i (second_z_i),
    .modulus_i  (modulus_i),
    .area_i     (area_i),
    .full_i     (full),
    .push_o     (push),
    .item_o     (front_item)
  );

  tes_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (queue_item)
  );

  // back end also owns the output bank and entry counters
  tes_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .pop_o         (pop),
    .item_i        (queue_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .row_o         (row_o),
    .column_o      (column_o),
    .entry_o       (entry_o),
    .zero_length_o (zero_length_o),
    .last_o        (last_o)
  );

endmodule

// ===== rtl/tes_front.sv =====
// front end: takes an element, forms axis differences and classifies it
module tes_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  first_x_i,
  input  logic signed [31:0]  first_y_i,
  input  logic signed [31:0]  first_z_i,
  input  logic signed [31:0]  second_x_i,
  input  logic signed [31:0]  second_y_i,
  input  logic signed [31:0]  second_z_i,
  input  logic [31:0]         modulus_i,
  input  logic [31:0]         area_i,
  input  logic                full_i,
  output logic                push_o,
  output tes_pkg::tes_item_t  item_o
);
  import tes_pkg::*;

  logic                 valid_q, valid_d;
  tes_item_t            item_q, item_d;
  logic [Axes-1:0][31:0] f, s;
  logic signed [32:0]   d [Axes];
  logic [32:0]          m [Axes];

  assign f = {first_z_i, first_y_i, first_x_i};
  assign s = {second_z_i, second_y_i, second_x_i};

  always_comb begin
    item_d = item_q;
    for (int i = 0; i < Axes; i++) begin
      d[i] = {s[i][31], s[i]} - {f[i][31], f[i]};
      m[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
      item_d.mag[i] = m[i][31:0];
      item_d.neg[i] = d[i][32];
    end
    item_d.zero    = (item_d.mag == '0);
    item_d.modulus = modulus_i;
    item_d.area    = area_i;
  end

  assign in_ready_o = !valid_q || !full_i;
  assign push_o     = valid_q && !full_i;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== rtl/tes_fifo.sv =====
// short queue of classified elements between front and back
module tes_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tes_pkg::tes_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output tes_pkg::tes_item_t item_o
);
  import tes_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tes_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/tes_back.sv =====
// back end: length, cosines, six magnitudes, then the 36 matrix entries
`include "truss_element_stiffness_macros.svh"
module tes_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  output logic               pop_o,
  input  tes_pkg::tes_item_t item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         row_o,
  output logic [2:0]         column_o,
  output logic signed [47:0] entry_o,
  output logic               zero_length_o,
  output logic               last_o
);
  import tes_pkg::*;

  tes_state_e        state_q, state_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [2:0]        pair_q, pair_d;
  logic [2:0]        sub_q, sub_d;
  tes_item_t         it_q, it_d;
  logic [SumW-1:0]   sum_q, sum_d, sq_q, sq_d;
  logic [EaW-1:0]    ea_q, ea_d;
  logic [SqRemW-1:0] rem_q, rem_d;
  logic [LenW-1:0]   root_q, root_d;
  logic [RemW-1:0]   qrem_q [Axes];
  logic [RemW-1:0]   qrem_d [Axes];
  logic [QW-1:0]     qlow_q [Axes];
  logic [QW-1:0]     qlow_d [Axes];
  logic [QqW-1:0]    qq_q, qq_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [RemW-1:0]   drem_q [Pairs];
  logic [RemW-1:0]   drem_d [Pairs];
  logic [QuotW-1:0]  dlow_q [Pairs];
  logic [QuotW-1:0]  dlow_d [Pairs];
  logic [Pairs-1:0]  sat_q, sat_d;

  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_p;
  logic [36:0]       sq_w, sq_t;
  logic [RemW-1:0]   q_w [Axes];
  logic [Axes-1:0]   q_ge;
  logic [RemW-1:0]   d_w [Pairs];
  logic [Pairs-1:0]  d_ge;
  logic [RemW-1:0]   len_ext;
  logic [RemW-1:0]   hi_part;

  // output bank
  logic              bank_valid_q, bank_valid_d;
  logic [QuotW-1:0]  bq_q [Pairs];
  logic [Pairs-1:0]  bsat_q;
  logic [Axes-1:0]   bneg_q;
  logic              bzero_q;
  logic [2:0]        r_q, r_d, c_q, c_d;
  logic              bank_free, bank_load, out_fire;

  assign mul_p   = {32'b0, mul_a} * {32'b0, mul_b};
  assign len_ext = {1'b0, root_q};
  assign hi_part = prod_q[124:91];

  // bit-serial datapaths: sqrt and nine divider lanes
  always_comb begin
    sq_w = {rem_q, sq_q[SumW-1:SumW-2]};
    sq_t = {2'b0, root_q, 2'b01};
    for (int i = 0; i < Axes; i++) begin
      q_w[i]  = {qrem_q[i][RemW-2:0], qlow_q[i][QW-1]};
      q_ge[i] = q_w[i] >= len_ext;
    end
    for (int j = 0; j < Pairs; j++) begin
      d_w[j]  = {drem_q[j][RemW-2:0], dlow_q[j][QuotW-1]};
      d_ge[j] = d_w[j] >= len_ext;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pair_d    = pair_q;
    sub_d     = sub_q;
    it_d      = it_q;
    sum_d     = sum_q;
    sq_d      = sq_q;
    ea_d      = ea_q;
    rem_d     = rem_q;
    root_d    = root_q;
    qrem_d    = qrem_q;
    qlow_d    = qlow_q;
    qq_d      = qq_q;
    prod_d    = prod_q;
    drem_d    = drem_q;
    dlow_d    = dlow_q;
    sat_d     = sat_q;
    mul_a     = '0;
    mul_b     = '0;
    pop_o     = 1'b0;
    bank_load = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          it_d    = item_i;
          sum_d   = '0;
          cnt_d   = '0;
          state_d = StSquare;
        end
      end
      StSquare: begin
        if (cnt_q < 6'(SquareSteps - 1)) begin
          mul_a = it_q.mag[cnt_q[1:0]];
          mul_b = it_q.mag[cnt_q[1:0]];
          sum_d = sum_q + SumW'(mul_p);
          cnt_d = cnt_q + 1'b1;
        end else begin
          mul_a   = it_q.modulus;
          mul_b   = it_q.area;
          ea_d    = mul_p;
          sq_d    = sum_q;
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = StSqrt;
        end
      end
      StSqrt: begin
        if (sq_w >= sq_t) begin
          rem_d = SqRemW'(sq_w - sq_t);
          root_d = {root_q[LenW-2:0], 1'b1};
        end else begin
          rem_d = sq_w[SqRemW-1:0];
          root_d = {root_q[LenW-2:0], 1'b0};
        end
        sq_d = {sq_q[SumW-3:0], 2'b00};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'(SqrtSteps - 1)) begin
          for (int i = 0; i < Axes; i++) begin
            qrem_d[i] = RemW'(it_q.mag[i][MagW-1:1]);
            qlow_d[i] = {it_q.mag[i][0], 30'b0};
          end
          cnt_d   = '0;
          state_d = StQdiv;
        end
      end
      StQdiv: begin
        for (int i = 0; i < Axes; i++) begin
          qrem_d[i] = q_ge[i] ? q_w[i] - len_ext : q_w[i];
          qlow_d[i] = {qlow_q[i][QW-2:0], q_ge[i]};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'(QSteps - 1)) begin
          cnt_d   = '0;
          pair_d  = '0;
          sub_d   = '0;
          state_d = StMul;
        end
      end
      StMul: begin
        sub_d = sub_q + 1'b1;
        unique case (sub_q)
          3'd0: begin
            mul_a = {1'b0, qlow_q[pair_row(pair_q)]};
            mul_b = {1'b0, qlow_q[pair_col(pair_q)]};
            qq_d  = mul_p[QqW-1:0];
          end
          3'd1: begin
            mul_a  = ea_q[31:0];
            mul_b  = qq_q[31:0];
            prod_d = ProdW'(mul_p);
          end
          3'd2: begin
            mul_a  = ea_q[31:0];
            mul_b  = {3'b0, qq_q[QqW-1:32]};
            prod_d = prod_q + {32'b0, mul_p, 32'b0};
          end
          3'd3: begin
            mul_a  = ea_q[63:32];
            mul_b  = qq_q[31:0];
            prod_d = prod_q + {32'b0, mul_p, 32'b0};
          end
          3'd4: begin
            mul_a  = ea_q[63:32];
            mul_b  = {3'b0, qq_q[QqW-1:32]};
            prod_d = prod_q + {mul_p, 64'b0};
          end
          default: begin
            // product >> 44: upper part seeds the remainder, lower part is shifted in
            drem_d[pair_q] = hi_part;
            dlow_d[pair_q] = prod_q[90:44];
            sat_d[pair_q]  = hi_part >= len_ext;
            sub_d          = '0;
            if (pair_q == 3'(Pairs - 1)) begin
              cnt_d   = '0;
              state_d = StDiv;
            end else begin
              pair_d = pair_q + 1'b1;
            end
          end
        endcase
      end
      StDiv: begin
        for (int j = 0; j < Pairs; j++) begin
          drem_d[j] = d_ge[j] ? d_w[j] - len_ext : d_w[j];
          dlow_d[j] = {dlow_q[j][QuotW-2:0], d_ge[j]};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'(DivSteps - 1)) begin
          state_d = StHand;
        end
      end
      StHand: begin
        if (bank_free) begin
          bank_load = 1'b1;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      pair_q  <= '0;
      sub_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pair_q  <= pair_d;
      sub_q   <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q   <= it_d;
    sum_q  <= sum_d;
    sq_q   <= sq_d;
    ea_q   <= ea_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    qrem_q <= qrem_d;
    qlow_q <= qlow_d;
    qq_q   <= qq_d;
    prod_q <= prod_d;
    drem_q <= drem_d;
    dlow_q <= dlow_d;
    sat_q  <= sat_d;
  end

  // entry emission from the bank
  logic [1:0]        ar, ac;
  logic [2:0]        pidx;
  logic              negv;
  logic [EntryW-1:0] vmag;

  assign out_valid_o   = bank_valid_q;
  assign out_fire      = bank_valid_q && out_ready_i;
  assign last_o        = (r_q == LastIdx) && (c_q == LastIdx);
  assign bank_free     = !bank_valid_q || (out_fire && last_o);
  assign row_o         = r_q;
  assign column_o      = c_q;
  assign zero_length_o = bzero_q;

  always_comb begin
    ar   = axis_of(r_q);
    ac   = axis_of(c_q);
    pidx = pair_of(ar, ac);
    negv = bneg_q[ar] ^ bneg_q[ac] ^ node_of(r_q) ^ node_of(c_q);
    if (bsat_q[pidx]) begin
      vmag = negv ? EntryNegMag : EntryPosMax;
    end else begin
      vmag = {1'b0, bq_q[pidx]};
    end
    if (bzero_q) begin
      entry_o = '0;
    end else begin
      entry_o = negv ? -vmag : vmag;
    end
  end

  always_comb begin
    r_d          = r_q;
    c_d          = c_q;
    bank_valid_d = bank_valid_q;
    if (out_fire) begin
      if (c_q == LastIdx) begin
        c_d = '0;
        r_d = (r_q == LastIdx) ? '0 : r_q + 1'b1;
      end else begin
        c_d = c_q + 1'b1;
      end
      if (last_o) begin
        bank_valid_d = 1'b0;
      end
    end
    if (bank_load) begin
      bank_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_valid_q <= 1'b0;
      r_q          <= '0;
      c_q          <= '0;
    end else begin
      bank_valid_q <= bank_valid_d;
      r_q          <= r_d;
      c_q          <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bank_load) begin
      bq_q    <= dlow_q;
      bsat_q  <= sat_q;
      bneg_q  <= it_q.neg;
      bzero_q <= it_q.zero;
    end
  end

  `TES_ASSERT_IMPLIES(a_zero_entry, out_valid_o && zero_length_o, entry_o == '0)
  `TES_ASSERT_NEXT(a_last_wraps, out_fire && last_o, (row_o == '0) && (column_o == '0))
  `TES_ASSERT_IMPLIES(a_cos_bound, (state_q == StMul) && !it_q.zero, (qlow_q[0] <= QOne) && (qlow_q[1] <= QOne) && (qlow_q[2] <= QOne))
  `TES_ASSERT_IMPLIES(a_load_free, bank_load, !bank_valid_q || (out_fire && last_o))

endmodule
